FILE: rtl/upe_pkg.sv
`timescale 1ns / 1ps

package upe_pkg;

    // Queue between classifier and serializer
    localparam int QUEUE_DEPTH_DEF = 2;
    // Most bytes one request can produce: broken triple plus escaped byte
    localparam int MAX_RUN = 7;

    typedef enum logic [1:0] {
        MODE_RFC      = 2'd0,
        MODE_KEEP_RES = 2'd1,
        MODE_FORM     = 2'd2,
        MODE_FORM_RES = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_PCT   = 2'd1,
        PEND_DIGIT = 2'd2
    } pend_t;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_TILDE   = 8'h7E;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_string_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_run_last;
        logic       out_string_end;
    } out_item_t;

    // One classified request: its output bytes in order and their count
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [2:0]              count;
        logic                    string_end;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alnum(logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    function automatic logic is_rsv_char(logic [7:0] c);
        logic r;
        unique case (c)
            8'h3A, 8'h2F, 8'h3F, 8'h23, 8'h5B, 8'h5D, 8'h40,
            8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A,
            8'h2B, 8'h2C, 8'h3B, 8'h3D: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Upper-case hex digit for one nibble
    function automatic logic [7:0] hex_char(logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
    endfunction

endpackage

FILE: rtl/upe_front.sv
`timescale 1ns / 1ps

module upe_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  upe_pkg::in_item_t s_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_data,
    input  upe_pkg::q_stat_t  q_stat,
    output logic              q_push,
    output upe_pkg::cmd_t     q_wdata
);
    import upe_pkg::*;

    mode_t      mode_reg;
    pend_t      pend_reg, pend_next;
    logic [7:0] digit_reg, digit_next;
    logic       accept;
    cmd_t       cmd;

    // Append one byte to a request
    function automatic cmd_t put(cmd_t cur, logic [7:0] b);
        cmd_t r;
        r = cur;
        r.bytes[cur.count] = b;
        r.count = cur.count + 3'd1;
        return r;
    endfunction

    function automatic cmd_t put_escaped(cmd_t cur, logic [7:0] c);
        cmd_t r;
        r = put(cur, CH_PERCENT);
        r = put(r, hex_char(c[7:4]));
        r = put(r, hex_char(c[3:0]));
        return r;
    endfunction

    // Release held bytes: a held '%' becomes %25, a held digit goes as is
    function automatic cmd_t put_flush(cmd_t cur, pend_t p, logic [7:0] d);
        cmd_t r;
        r = cur;
        if (p != PEND_NONE) begin
            r = put_escaped(r, CH_PERCENT);
        end
        if (p == PEND_DIGIT) begin
            r = put(r, d);
        end
        return r;
    endfunction

    function automatic cmd_t put_encoded(cmd_t cur, logic [7:0] c, mode_t m);
        cmd_t r;
        logic base;
        logic pass;
        base = is_alnum(c) || (c == CH_DASH) || (c == CH_DOT) || (c == CH_UNDER);
        unique case (m)
            MODE_RFC:      pass = base || (c == CH_TILDE);
            MODE_KEEP_RES: pass = base || (c == CH_TILDE) || is_rsv_char(c);
            MODE_FORM:     pass = base || (c == CH_STAR);
            MODE_FORM_RES: pass = (base || (c == CH_STAR) || is_rsv_char(c)) &&
                                  (c != CH_AMP) && (c != CH_EQUAL) && (c != CH_PLUS);
            default:       pass = 1'b0;
        endcase
        if (m[1] && (c == CH_SPACE)) begin
            r = put(cur, CH_PLUS);
        end else if (pass) begin
            r = put(cur, c);
        end else begin
            r = put_escaped(cur, c);
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_stat.full;
    assign accept    = s_valid && s_ready;

    // Classify the request and build its output run
    always_comb begin
        logic       keeps;
        logic       fresh;
        logic [7:0] c;
        keeps      = mode_reg[0];
        c          = s_data.in_byte;
        fresh      = 1'b1;
        pend_next  = pend_reg;
        digit_next = digit_reg;
        cmd        = '0;
        cmd.string_end = s_data.in_string_end;
        unique case (pend_reg)
            PEND_DIGIT: begin
                if (keeps && is_hex(c)) begin
                    cmd   = put(cmd, CH_PERCENT);
                    cmd   = put(cmd, digit_reg);
                    cmd   = put(cmd, c);
                    fresh = 1'b0;
                end else begin
                    cmd = put_flush(cmd, pend_reg, digit_reg);
                end
                pend_next  = PEND_NONE;
                digit_next = '0;
            end
            PEND_PCT: begin
                if (keeps && is_hex(c)) begin
                    pend_next  = PEND_DIGIT;
                    digit_next = c;
                    fresh      = 1'b0;
                end else begin
                    cmd        = put_flush(cmd, pend_reg, digit_reg);
                    pend_next  = PEND_NONE;
                    digit_next = '0;
                end
            end
            default: begin
            end
        endcase
        if (fresh) begin
            if (keeps && (c == CH_PERCENT)) begin
                pend_next = PEND_PCT;
            end else begin
                cmd = put_encoded(cmd, c, mode_reg);
            end
        end
        if (s_data.in_string_end) begin
            cmd        = put_flush(cmd, pend_next, digit_next);
            pend_next  = PEND_NONE;
            digit_next = '0;
        end
    end

    assign q_wdata = cmd;
    // Drop requests that only hold their byte
    assign q_push  = accept && (cmd.count != 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_RFC;
            pend_reg  <= PEND_NONE;
            digit_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= mode_t'(cfg_data);
            end
            if (accept) begin
                pend_reg  <= pend_next;
                digit_reg <= digit_next;
            end
        end
    end

endmodule

FILE: rtl/upe_queue.sv
`timescale 1ns / 1ps

module upe_queue #(
    parameter int DEPTH = upe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  upe_pkg::cmd_t    wdata,
    input  logic             pop,
    output upe_pkg::cmd_t    rdata,
    output upe_pkg::q_stat_t stat
);
    import upe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign stat.valid = (count_reg != '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign rdata      = mem[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Store the request at the tail
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/upe_back.sv
`timescale 1ns / 1ps

module upe_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  upe_pkg::q_stat_t   q_stat,
    input  upe_pkg::cmd_t      q_rdata,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output upe_pkg::out_item_t m_data
);
    import upe_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    out_item_t  m_data_reg, m_data_next;
    logic       load;
    logic       run_last;

    assign load     = q_stat.valid && (!m_valid_reg || m_ready);
    assign run_last = (idx_reg == (q_rdata.count - 3'd1));
    assign q_pop    = load && run_last;

    // Pick the next byte of the head request
    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next               = 1'b1;
            m_data_next.out_byte       = q_rdata.bytes[idx_reg];
            m_data_next.out_run_last   = run_last;
            m_data_next.out_string_end = run_last && q_rdata.string_end;
            idx_next                   = run_last ? 3'd0 : idx_reg + 3'd1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the result byte until taken
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/url_percent_encoder.sv
`timescale 1ns / 1ps
// Channel   Ports                          Direction  Carries
// input     s_valid, s_ready, s_data       in         raw byte, end-of-string flag
// result    m_valid, m_ready, m_data       out        encoded byte, run/string ends
// config    cfg_valid, cfg_ready, cfg_data in         encode mode (2 bits)
//
// One output byte per cycle from the serializer while m_ready is high; a passed byte
// gives 1 output byte, an escaped byte 3, a broken triple with an escaped byte up to 7.
// The classifier takes a request every cycle while the queue has room.
// Reset (aresetn low, synchronous) clears mode to rfc3986, held bytes and queue.
// Either side may stall; the queue and output register keep the other moving.

module url_percent_encoder #(
    parameter int QUEUE_DEPTH = upe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  upe_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output upe_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_data
);
    import upe_pkg::*;

    q_stat_t q_stat;
    logic    q_push;
    logic    q_pop;
    cmd_t    q_wdata;
    cmd_t    q_rdata;

    upe_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    upe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .stat    (q_stat)
    );

    upe_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_stat  (q_stat),
        .q_rdata (q_rdata),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // A queued request always carries at least one byte and at most seven
    a_push_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (q_wdata.count != 3'd0) && (q_wdata.count <= 3'd7))
        else $error("empty or oversized request queued");

    // String end only marks the last byte of a run
    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_string_end |-> m_data.out_run_last)
        else $error("string end without run end");

    // Never pop an empty queue
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_stat.valid)
        else $error("pop from empty queue");

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid after reset");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import upe_pkg::*;

    localparam int    HALF_PERIOD = 5;
    localparam int    RESET_CYCLES = 8;
    localparam int    TAIL_CYCLES = 24;
    localparam int    PHASE_ITEMS = 20;
    localparam int    REPORT_LIMIT = 10;
    localparam int    TIMEOUT_NS = 3_000_000;

    localparam string UPPER_HEX = "0123456789ABCDEF";
    localparam string ANY_HEX = "0123456789ABCDEFabcdef";
    localparam string ALNUM_SET =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
    localparam string RESERVED_SET = ":/?#[]@!$&'()*+,;=";
    localparam string MARK_SET = "-._~*";

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_data = '0;

    // Encoder state as the block should hold it
    mode_t      enc_mode = MODE_RFC;
    pend_t      held_state = PEND_NONE;
    logic [7:0] held_digit = '0;

    in_item_t   pending_requests[$];
    out_item_t  expected_bytes[$];
    logic [7:0] run_bytes[$];

    logic       in_taken = 1'b0;
    int         burst_left = 0;
    int         gap_left = 0;
    logic [15:0] ready_pattern = 16'hFFFF;
    int         pattern_age = 0;

    int         mismatches = 0;
    int         requests_seen = 0;
    int         bytes_seen = 0;
    int         mode_writes = 0;
    logic [3:0] modes_used = '0;

    url_percent_encoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // ---------------- prediction ----------------

    function automatic logic in_string(string set, logic [7:0] c);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < set.len(); i++) begin
            if (set[i] == c) hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic logic is_hex_char(logic [7:0] c);
        return in_string(ANY_HEX, c);
    endfunction

    task automatic push_escaped(input logic [7:0] c);
        run_bytes.push_back(CH_PERCENT);
        run_bytes.push_back(UPPER_HEX[c[7:4]]);
        run_bytes.push_back(UPPER_HEX[c[3:0]]);
    endtask

    // Encode one byte that is not part of a held triple
    task automatic encode_plain(input logic [7:0] c);
        logic plain;
        logic unres;
        unres = in_string(ALNUM_SET, c) || c == CH_DASH || c == CH_DOT || c == CH_UNDER;
        if (enc_mode >= MODE_FORM && c == CH_SPACE) begin
            run_bytes.push_back(CH_PLUS);
            return;
        end
        case (enc_mode)
            MODE_RFC: begin
                plain = unres || c == CH_TILDE;
            end
            MODE_KEEP_RES: begin
                plain = unres || c == CH_TILDE || in_string(RESERVED_SET, c);
            end
            MODE_FORM: begin
                plain = unres || c == CH_STAR;
            end
            default: begin
                plain = (unres || c == CH_STAR || in_string(RESERVED_SET, c)) &&
                        c != CH_AMP && c != CH_EQUAL && c != CH_PLUS;
            end
        endcase
        if (plain) run_bytes.push_back(c);
        else push_escaped(c);
    endtask

    // Release held bytes as a broken triple
    task automatic flush_held();
        if (held_state != PEND_NONE) push_escaped(CH_PERCENT);
        if (held_state == PEND_DIGIT) run_bytes.push_back(held_digit);
        held_state = PEND_NONE;
        held_digit = '0;
    endtask

    // Work out the bytes one accepted request must produce
    task automatic encode_request(input in_item_t req);
        logic      keeps;
        logic      fresh;
        out_item_t item;
        keeps = enc_mode[0];
        fresh = 1'b1;
        run_bytes.delete();
        if (held_state == PEND_DIGIT) begin
            if (keeps && is_hex_char(req.in_byte)) begin
                run_bytes.push_back(CH_PERCENT);
                run_bytes.push_back(held_digit);
                run_bytes.push_back(req.in_byte);
                held_state = PEND_NONE;
                held_digit = '0;
                fresh = 1'b0;
            end else begin
                flush_held();
            end
        end else if (held_state == PEND_PCT) begin
            if (keeps && is_hex_char(req.in_byte)) begin
                held_digit = req.in_byte;
                held_state = PEND_DIGIT;
                fresh = 1'b0;
            end else begin
                flush_held();
            end
        end
        if (fresh) begin
            if (keeps && req.in_byte == CH_PERCENT) held_state = PEND_PCT;
            else encode_plain(req.in_byte);
        end
        if (req.in_string_end) flush_held();
        foreach (run_bytes[i]) begin
            item.out_byte = run_bytes[i];
            item.out_run_last = (i == run_bytes.size() - 1);
            item.out_string_end = req.in_string_end && (i == run_bytes.size() - 1);
            expected_bytes.push_back(item);
        end
    endtask

    // ---------------- request driver ----------------

    // Hold an unaccepted request, otherwise send in bursts with gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            s_valid <= 1'b1;
        end else if (gap_left > 0) begin
            s_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_requests.size() > 0) begin
            s_valid <= 1'b1;
            s_data <= pending_requests.pop_front();
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 12);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // ---------------- result receiver ----------------

    // Rotate a stall pattern, reload a new one whenever pattern_age reaches its limit
    always @(negedge aclk) begin
        m_ready <= ready_pattern[0];
        if (pattern_age >= 48) begin
            pattern_age <= 0;
            if ($urandom_range(0, 3) == 0) ready_pattern <= 16'hFFFF;
            else ready_pattern <= 16'($urandom) | 16'h0001;
        end else begin
            pattern_age <= pattern_age + 1;
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        end
    end

    // ---------------- monitor ----------------

    // Predict on each accepted request, check each accepted result
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && s_valid && s_ready) begin
            in_taken <= 1'b1;
            requests_seen <= requests_seen + 1;
            encode_request(s_data);
        end else begin
            in_taken <= 1'b0;
        end
        if (aresetn && m_valid && m_ready) begin
            bytes_seen <= bytes_seen + 1;
            if (expected_bytes.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < REPORT_LIMIT)
                    $display("ERROR: unexpected byte %02h run_last %0b string_end %0b",
                             m_data.out_byte, m_data.out_run_last,
                             m_data.out_string_end);
            end else begin
                want = expected_bytes.pop_front();
                if (m_data !== want) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < REPORT_LIMIT)
                        $display({"ERROR: byte exp %02h got %02h, run_last exp %0b got %0b,",
                                  " string_end exp %0b got %0b"},
                                 want.out_byte, m_data.out_byte,
                                 want.out_run_last, m_data.out_run_last,
                                 want.out_string_end, m_data.out_string_end);
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic add_request(input logic [7:0] c, input logic last);
        in_item_t req;
        req.in_byte = c;
        req.in_string_end = last;
        pending_requests.push_back(req);
    endtask

    task automatic add_text(input string text, input logic last);
        for (int i = 0; i < text.len(); i++)
            add_request(text[i], last && (i == text.len() - 1));
    endtask

    // Wait for every request to go out and every byte to come back
    task automatic wait_drained();
        while (pending_requests.size() != 0 || s_valid || expected_bytes.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input mode_t m);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        enc_mode = m;
        mode_writes++;
        modes_used[m] = 1'b1;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One random string: triples, broken triples, and bytes of every class
    task automatic add_random_string();
        in_item_t text[$];
        in_item_t req;
        int       len;
        int       kind;
        len = $urandom_range(1, 8);
        req.in_string_end = 1'b0;
        while (text.size() < len) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1: begin
                    req.in_byte = CH_PERCENT;
                    text.push_back(req);
                    req.in_byte = ANY_HEX[$urandom_range(0, 21)];
                    text.push_back(req);
                    req.in_byte = ANY_HEX[$urandom_range(0, 21)];
                    text.push_back(req);
                end
                2: begin
                    req.in_byte = CH_PERCENT;
                    text.push_back(req);
                end
                3: begin
                    req.in_byte = CH_SPACE;
                    text.push_back(req);
                end
                4: begin
                    req.in_byte = ALNUM_SET[$urandom_range(0, 61)];
                    text.push_back(req);
                end
                5: begin
                    req.in_byte = RESERVED_SET[$urandom_range(0, 17)];
                    text.push_back(req);
                end
                6: begin
                    req.in_byte = MARK_SET[$urandom_range(0, 4)];
                    text.push_back(req);
                end
                default: begin
                    req.in_byte = 8'($urandom_range(0, 255));
                    text.push_back(req);
                end
            endcase
        end
        // Leave some strings open so they run on into the next one
        if ($urandom_range(0, 7) != 0) text[text.size() - 1].in_string_end = 1'b1;
        foreach (text[i]) pending_requests.push_back(text[i]);
    endtask

    task automatic add_random_phase(input int count);
        int start;
        start = pending_requests.size();
        while (pending_requests.size() - start < count) add_random_string();
    endtask

    initial begin
        mode_t phase_modes[6];
        phase_modes = '{MODE_FORM_RES, MODE_RFC, MODE_KEEP_RES, MODE_FORM,
                        mode_t'($urandom_range(0, 3)), mode_t'($urandom_range(0, 3))};
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        modes_used[MODE_RFC] = 1'b1;

        // Reset mode: byte extremes, space, tilde, lone percent at string end
        add_request(8'h00, 1'b0);
        add_request(8'hFF, 1'b0);
        add_request(CH_SPACE, 1'b0);
        add_request(CH_TILDE, 1'b0);
        add_request(CH_PERCENT, 1'b1);
        wait_drained();

        // Keep-reserved: valid triple, broken triples, flush at string end
        write_mode(MODE_KEEP_RES);
        add_text("%4a%G%f%", 1'b0);
        add_request(CH_PERCENT, 1'b1);
        add_text("%B", 1'b1);
        add_request(CH_PERCENT, 1'b0);
        wait_drained();

        // Form with a percent still held from the mode before
        write_mode(MODE_FORM);
        add_text("4 *&", 1'b1);
        wait_drained();

        // Form keeping reserved: escaped & = +, passed reserved, space
        write_mode(MODE_FORM_RES);
        add_text("&=+: ", 1'b1);
        wait_drained();

        foreach (phase_modes[p]) begin
            write_mode(phase_modes[p]);
            if (p == 2) begin
                // Pause the sender until everything is back, mid-phase
                add_random_phase(PHASE_ITEMS / 2);
                wait_drained();
                add_random_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
            end else begin
                add_random_phase(PHASE_ITEMS);
            end
            wait_drained();
        end

        $display("Sent %0d requests, checked %0d encoded bytes", requests_seen, bytes_seen);
        $display("Mode writes: %0d, modes exercised mask %04b", mode_writes, modes_used);
        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Mismatches: %0d", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d bytes still expected", expected_bytes.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/upe_pkg.sv
rtl/upe_front.sv
rtl/upe_queue.sv
rtl/upe_back.sv
rtl/url_percent_encoder.sv
sim/testbench.sv
